/* rtl/sba_pkg.sv */
package sba_pkg;

    // Window geometry: depth is always a power of two
    localparam int LOG2_DEPTH = 3;
    localparam int DEPTH      = 1 << LOG2_DEPTH;

    // Field and datapath widths
    localparam int SAMPLE_W = 15;
    localparam int OFFSET_W = 11;
    localparam int ENTRY_W  = 17;
    localparam int SUM_W    = ENTRY_W + LOG2_DEPTH;
    localparam int AVG_W    = 16;

    // Constants
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -11'sd140;
    localparam logic signed [AVG_W-1:0]    AVG_INVALID  = -16'sd1;
    localparam logic signed [AVG_W-1:0]    AVG_MAX      = 16'sd32767;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // Window state after the current beat, handed from the ring to the top
    typedef struct packed {
        logic valid;
        t_sum sum;
    } t_win_next;

endpackage

/* rtl/sba_cell.sv */
module sba_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_load,
    input  sba_pkg::t_entry i_load_data,
    input  sba_pkg::t_entry i_prev,
    output sba_pkg::t_entry o_data
);
    import sba_pkg::*;

    t_entry r_data;

    // Load the fill value on a refill, otherwise take the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/sba_ring.sv */
module sba_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_bad,
    input  sba_pkg::t_entry    i_value,
    output sba_pkg::t_win_next o_next
);
    import sba_pkg::*;

    logic   r_valid;
    t_sum   r_sum;
    t_entry w_tap [DEPTH];
    logic   w_fill;
    logic   w_shift;
    logic   n_valid;
    t_sum   n_sum;

    // Refill on the first good beat after invalidity, shift on later good beats
    assign w_fill  = i_step && !i_bad && !r_valid;
    assign w_shift = i_step && !i_bad && r_valid;

    // Chain of cells: cell 0 takes the new entry, the last cell holds the oldest
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry w_prev;
        if (k == 0) begin : g_head
            assign w_prev = i_value;
        end else begin : g_body
            assign w_prev = w_tap[k-1];
        end
        sba_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_load      (w_fill),
            .i_load_data (i_value),
            .i_prev      (w_prev),
            .o_data      (w_tap[k])
        );
    end

    // Running sum: whole window on refill, new minus oldest on a shift; a bad beat clears validity
    always_comb begin
        n_valid = r_valid;
        n_sum   = r_sum;
        if (i_step) begin
            if (i_bad) begin
                n_valid = 1'b0;
            end else if (!r_valid) begin
                n_valid = 1'b1;
                n_sum   = t_sum'({i_value, {LOG2_DEPTH{1'b0}}});
            end else begin
                n_sum = r_sum + t_sum'(i_value) - t_sum'(w_tap[DEPTH-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_valid <= n_valid;
            r_sum   <= n_sum;
        end
    end

    assign o_next.valid = n_valid;
    assign o_next.sum   = n_sum;

endmodule

/* rtl/sensor_boxcar_average_with_validity_unit.sv */
// Boxcar average of calibrated temperature samples with a validity flag.
// Input channel: i_in_valid / o_in_ready carry i_sample (hundredths of a
// degree) and i_sample_bad. Output channel: o_out_valid / i_out_ready carry
// o_average and o_is_valid, one result beat for every input beat, in order.
// A good sample gets the calibration offset added and enters a window of
// DEPTH entries held in a chain of cells; the first good sample after a bad
// one fills the whole window. The average is the window mean truncated toward
// zero and clipped at 32767, or -1 with o_is_valid low while invalid.
// Results are registered: a beat accepted while the output is free shows
// there in the following cycle. One beat per cycle is taken while
// o_in_ready is high. The calibration offset is written through i_cfg_we /
// i_cfg_data while the unit is idle; the user must keep to this, as the unit
// does not enforce it. Reset clears the valid state, empties both channels
// and sets the offset to -140. When the receiver stalls, one further beat is
// held in a skid register and o_in_ready then drops until the output drains.
module sensor_boxcar_average_with_validity_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic signed [sba_pkg::OFFSET_W-1:0] i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [sba_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_sample_bad,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sba_pkg::AVG_W-1:0]    o_average,
    output logic                                o_is_valid
);
    import sba_pkg::*;

    logic signed [OFFSET_W-1:0] r_offset;
    logic                       r_out_valid;
    logic signed [AVG_W-1:0]    r_out_avg;
    logic                       r_out_ok;
    logic                       r_skd_valid;
    logic signed [AVG_W-1:0]    r_skd_avg;
    logic                       r_skd_ok;

    logic                       w_accept;
    logic                       w_out_free;
    t_entry                     w_value;
    t_win_next                  w_next;
    t_sum                       w_adj;
    t_entry                     w_mean;
    logic signed [AVG_W-1:0]    n_avg;

    assign w_accept   = i_in_valid && !r_skd_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Apply the calibration offset
    assign w_value = t_entry'({{(ENTRY_W-SAMPLE_W){1'b0}}, i_sample})
                   + t_entry'(r_offset);

    sba_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_bad   (i_sample_bad),
        .i_value (w_value),
        .o_next  (w_next)
    );

    // Divide by depth toward zero, clip, or flag invalid
    always_comb begin
        w_adj  = w_next.sum + (w_next.sum[SUM_W-1] ? t_sum'(DEPTH - 1) : t_sum'(0));
        w_mean = t_entry'(w_adj[SUM_W-1:LOG2_DEPTH]);
        if (!w_next.valid) begin
            n_avg = AVG_INVALID;
        end else if (w_mean > t_entry'(AVG_MAX)) begin
            n_avg = AVG_MAX;
        end else begin
            n_avg = w_mean[AVG_W-1:0];
        end
    end

    // Control: offset register and output / skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= OFFSET_RESET;
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            if (w_out_free) begin
                r_out_valid <= r_skd_valid || w_accept;
                r_skd_valid <= 1'b0;
            end else if (w_accept) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    // Payload: advance skid into output, or park the new beat in the skid
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skd_valid) begin
                r_out_avg <= r_skd_avg;
                r_out_ok  <= r_skd_ok;
            end else begin
                r_out_avg <= n_avg;
                r_out_ok  <= w_next.valid;
            end
        end else if (w_accept) begin
            r_skd_avg <= n_avg;
            r_skd_ok  <= w_next.valid;
        end
    end

    assign o_in_ready  = !r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_average   = r_out_avg;
    assign o_is_valid  = r_out_ok;

endmodule

/* rtl/sba_checker.sv */
module sba_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [sba_pkg::AVG_W-1:0] o_average,
    input logic                             o_is_valid
);
    import sba_pkg::*;

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Held beat stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_average) && $stable(o_is_valid))
        else $error("stalled result changed");

    // Invalid results carry the invalid marker
    a_invalid_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_valid |-> o_average == AVG_INVALID)
        else $error("invalid result without marker");

    // Input stalls only when the output side is full
    a_ready_backs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind sensor_boxcar_average_with_validity_unit sba_checker u_sba_checker (.*);
